// ----- src/tcfs_pkg.sv -----
// Shared types and constants of the tone, chirp and fade sequencer.
`timescale 1ns / 1ps
package tcfs_pkg;

  // Command kinds. Any code that is neither silence nor chirp plays as a tone.
  localparam logic [1:0] REQ_TONE    = 2'd0;
  localparam logic [1:0] REQ_SILENCE = 2'd1;
  localparam logic [1:0] REQ_CHIRP   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOLUME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_ON       = 1'd1;
  localparam int unsigned CFG_DATA_W = 7;

  // Reciprocal constants for division by a constant.
  localparam int unsigned SHIFT_100 = 19;
  localparam logic [24:0] RECIP_100 = 25'd5243;
  localparam int unsigned DIV_K     = 24;
  localparam logic [24:0] RECIP_10  = 25'd1677722;

  localparam logic [6:0] PCT_MAX = 7'd100;

  // One datapath operation per cycle while the segment parameters are worked out.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_VM,
    OP_VM_DIV,
    OP_MUL255,
    OP_DUTY_DIV,
    OP_HOLD,
    OP_DIFF,
    OP_STEADY,
    OP_PREP
  } dp_op_t;

  // Kind of segment to load into the output register.
  typedef enum logic [2:0] {
    SEG_NONE,
    SEG_SILENCE,
    SEG_CHIRP,
    SEG_STEADY,
    SEG_FADE,
    SEG_OFF
  } seg_sel_t;

  typedef struct packed {
    dp_op_t   op;
    seg_sel_t seg;
  } dp_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic [1:0] req_type;
    logic       fade_on;
    logic       fade_live;
  } dp_status_t;

endpackage

// ----- src/tcfs_if.sv -----
// Handshake channel interfaces for commands, segments and configuration writes.
`timescale 1ns / 1ps
interface tcfs_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] start_freq;
  logic [15:0] end_freq;
  logic [15:0] duration_ms;
  logic [7:0]  volume;
  logic        fade_on;

  modport source (output valid, req_type, start_freq, end_freq, duration_ms, volume, fade_on,
                  input ready);
  modport sink (input valid, req_type, start_freq, end_freq, duration_ms, volume, fade_on,
                output ready);
endinterface

interface tcfs_seg_if;
  logic        valid;
  logic        ready;
  logic [15:0] tone_freq;
  logic [7:0]  duty;
  logic [15:0] hold_ms;
  logic        last;

  modport source (output valid, tone_freq, duty, hold_ms, last, input ready);
  modport sink (input valid, tone_freq, duty, hold_ms, last, output ready);
endinterface

interface tcfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] reg_index;
  logic [6:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ----- src/tcfs_dp.sv -----
// Datapath: configuration registers, shared multiplier, segment registers and output register.
`timescale 1ns / 1ps
module tcfs_dp #(
  parameter int unsigned CHIRP_STEPS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  tcfs_pkg::dp_cmd_t   cmd,
  output tcfs_pkg::dp_status_t status,
  input  logic [1:0]          in_req_type,
  input  logic [15:0]         in_start_freq,
  input  logic [15:0]         in_end_freq,
  input  logic [15:0]         in_duration_ms,
  input  logic [7:0]          in_volume,
  input  logic                in_fade_on,
  tcfs_cfg_if.sink            cfg,
  tcfs_seg_if.source          seg
);
  import tcfs_pkg::*;

  localparam logic [24:0] RECIP_N = 25'((2**DIV_K + CHIRP_STEPS - 1) / CHIRP_STEPS);

  // Configuration.
  logic [6:0] master_volume;
  logic       mute_on;

  // Latched command.
  logic [1:0]  req_type;
  logic [15:0] f0;
  logic [15:0] f1;
  logic [15:0] dur;
  logic [7:0]  vol;
  logic        fade;

  // Worked-out segment parameters.
  logic [43:0] mul_q;
  logic [7:0]  duty_r;
  logic [15:0] hold_r;
  logic [15:0] df_r;
  logic [15:0] steady_r;
  logic [12:0] fhold_r;
  logic [15:0] freq_r;
  logic [7:0]  v_r;

  logic [18:0] mul_a;
  logic [24:0] mul_b;
  logic [6:0]  vol_c;
  logic [6:0]  mv_c;
  logic [16:0] diff;
  logic [15:0] diff_mag;
  logic [18:0] dur7;
  logic [15:0] rest;
  logic [7:0]  fstep;
  logic        out_free;

  assign cfg.ready = 1'b1;

  assign vol_c    = (vol > 8'(PCT_MAX)) ? PCT_MAX : vol[6:0];
  assign mv_c     = (master_volume > PCT_MAX) ? PCT_MAX : master_volume;
  assign diff     = {1'b0, f1} - {1'b0, f0};
  assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
  assign dur7     = {dur, 3'b000} - {3'b000, dur};
  assign rest     = dur - mul_q[DIV_K +: 16];
  assign fstep    = (duty_r[7:3] == 5'd0) ? 8'd1 : {3'b000, duty_r[7:3]};
  assign out_free = !seg.valid || seg.ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_VM: begin
        mul_a = {12'd0, vol_c};
        mul_b = {18'd0, mv_c};
      end
      OP_VM_DIV: begin
        mul_a = {5'd0, mul_q[13:0]};
        mul_b = RECIP_100;
      end
      OP_MUL255: begin
        mul_a = {12'd0, mul_q[SHIFT_100 +: 7]};
        mul_b = 25'd255;
      end
      OP_DUTY_DIV: begin
        mul_a = {4'd0, mul_q[14:0]};
        mul_b = RECIP_100;
      end
      OP_HOLD: begin
        mul_a = {3'd0, dur};
        mul_b = RECIP_N;
      end
      OP_DIFF: begin
        mul_a = {3'd0, diff_mag};
        mul_b = RECIP_N;
      end
      OP_STEADY: begin
        mul_a = dur7;
        mul_b = RECIP_10;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume <= 7'd70;
      mute_on       <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.reg_index == CFG_MASTER_VOLUME) begin
        master_volume <= cfg.wdata;
      end else begin
        mute_on <= cfg.wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_q <= 44'(mul_a * mul_b);
    case (cmd.op)
      OP_LOAD: begin
        req_type <= in_req_type;
        f0       <= in_start_freq;
        f1       <= in_end_freq;
        dur      <= in_duration_ms;
        vol      <= in_volume;
        fade     <= in_fade_on;
      end
      OP_HOLD: begin
        duty_r <= mute_on ? 8'd0 : mul_q[SHIFT_100 +: 8];
      end
      OP_DIFF: begin
        hold_r <= mul_q[DIV_K +: 16];
        v_r    <= duty_r;
        freq_r <= f0;
      end
      OP_STEADY: begin
        df_r <= diff[16] ? 16'(-mul_q[DIV_K +: 16]) : mul_q[DIV_K +: 16];
      end
      OP_PREP: begin
        steady_r <= mul_q[DIV_K +: 16];
        fhold_r  <= rest[15:3];
      end
      default: begin
      end
    endcase
    if (cmd.seg == SEG_CHIRP) begin
      freq_r <= freq_r + df_r;
    end
    if (cmd.seg == SEG_FADE) begin
      v_r <= (v_r <= fstep) ? 8'd0 : v_r - fstep;
    end
  end

  // Output register: loads a segment when commanded, which happens only while it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
    end else if (cmd.seg != SEG_NONE) begin
      seg.valid <= 1'b1;
    end else if (seg.ready) begin
      seg.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.seg)
      SEG_SILENCE: begin
        seg.tone_freq <= 16'd0;
        seg.duty      <= 8'd0;
        seg.hold_ms   <= dur;
        seg.last      <= 1'b1;
      end
      SEG_CHIRP: begin
        seg.tone_freq <= freq_r;
        seg.duty      <= duty_r;
        seg.hold_ms   <= hold_r;
        seg.last      <= 1'b0;
      end
      SEG_STEADY: begin
        seg.tone_freq <= f0;
        seg.duty      <= duty_r;
        seg.hold_ms   <= fade ? steady_r : dur;
        seg.last      <= 1'b0;
      end
      SEG_FADE: begin
        seg.tone_freq <= f0;
        seg.duty      <= v_r;
        seg.hold_ms   <= {3'd0, fhold_r};
        seg.last      <= 1'b0;
      end
      SEG_OFF: begin
        seg.tone_freq <= 16'd0;
        seg.duty      <= 8'd0;
        seg.hold_ms   <= 16'd0;
        seg.last      <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign status.out_free  = out_free;
  assign status.req_type  = req_type;
  assign status.fade_on   = fade;
  assign status.fade_live = (v_r != 8'd0);

  // A segment is only loaded into a free output register.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.seg != SEG_NONE |-> out_free)
    else $error("segment loaded over an untaken result");

  // Each fade step lowers the duty strictly.
  a_fade_falls: assert property (@(posedge clk) disable iff (rst)
    cmd.seg == SEG_FADE |=> v_r < $past(v_r))
    else $error("fade duty did not fall");

endmodule

// ----- src/tcfs_ctrl.sv -----
// Controller: sequences the arithmetic steps and the segment emission of one command.
`timescale 1ns / 1ps
module tcfs_ctrl #(
  parameter int unsigned CHIRP_STEPS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcfs_pkg::dp_status_t status,
  output tcfs_pkg::dp_cmd_t    cmd
);
  import tcfs_pkg::*;

  localparam int unsigned CNT_W = $clog2(CHIRP_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_VM,
    S_VM_DIV,
    S_MUL255,
    S_DUTY_DIV,
    S_HOLD,
    S_DIFF,
    S_STEADY,
    S_PREP,
    S_MAIN,
    S_CHIRP,
    S_FADE,
    S_OFF
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             cnt_end;

  assign cnt_end  = (cnt == CNT_W'(CHIRP_STEPS - 1));
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NOP;
    cmd.seg    = SEG_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_VM;
        end
      end
      S_VM: begin
        cmd.op     = OP_VM;
        state_next = S_VM_DIV;
      end
      S_VM_DIV: begin
        cmd.op     = OP_VM_DIV;
        state_next = S_MUL255;
      end
      S_MUL255: begin
        cmd.op     = OP_MUL255;
        state_next = S_DUTY_DIV;
      end
      S_DUTY_DIV: begin
        cmd.op     = OP_DUTY_DIV;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        cmd.op     = OP_HOLD;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_STEADY;
      end
      S_STEADY: begin
        cmd.op     = OP_STEADY;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.op     = OP_PREP;
        state_next = S_MAIN;
      end
      S_MAIN: begin
        if (status.req_type == REQ_CHIRP) begin
          cnt_next   = '0;
          state_next = S_CHIRP;
        end else if (status.out_free) begin
          if (status.req_type == REQ_SILENCE) begin
            cmd.seg    = SEG_SILENCE;
            state_next = S_IDLE;
          end else begin
            cmd.seg    = SEG_STEADY;
            state_next = status.fade_on ? S_FADE : S_OFF;
          end
        end
      end
      S_CHIRP: begin
        if (status.out_free) begin
          cmd.seg  = SEG_CHIRP;
          cnt_next = cnt + CNT_W'(1);
          if (cnt_end) begin
            state_next = S_OFF;
          end
        end
      end
      S_FADE: begin
        if (!status.fade_live) begin
          state_next = S_OFF;
        end else if (status.out_free) begin
          cmd.seg = SEG_FADE;
        end
      end
      S_OFF: begin
        if (status.out_free) begin
          cmd.seg    = SEG_OFF;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // No segment is emitted while a new command can be taken.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> cmd.seg == SEG_NONE)
    else $error("segment emitted while idle");

  // The final chirp step is followed by the off segment.
  a_chirp_to_off: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHIRP && cmd.seg == SEG_CHIRP && cnt_end) |=> state == S_OFF)
    else $error("chirp did not end with the off segment");

endmodule

// ----- src/tone_chirp_fade_sequencer_top.sv -----
// Top level of the tone, chirp and fade buzzer segment sequencer.
`timescale 1ns / 1ps
// Each transfer on cmd is one sound command, and it comes out on seg as an ordered run
// of buzzer segments (frequency, eight-bit duty, hold time in milliseconds) whose final
// segment carries last. Silence gives one segment, a chirp gives CHIRP_STEPS steps and an
// off segment, and a tone gives a steady segment, an optional stepped fade-out of up to fifteen
// segments, and an off segment. After a command is taken, the datapath works out duty, step
// hold, chirp step and fade hold on its single shared multiplier, one multiplication per cycle.
// Segments then leave at most one per cycle while seg is ready. The output register lets a new
// command be taken while the last segment of the previous one still waits. Writes on cfg
// are always taken; they are expected only while no command is in progress.
module tone_chirp_fade_sequencer_top #(
  parameter int unsigned CHIRP_STEPS = 20
) (
  input logic       clk,
  input logic       rst,
  tcfs_cmd_if.sink  cmd,
  tcfs_seg_if.source seg,
  tcfs_cfg_if.sink  cfg
);
  import tcfs_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  tcfs_ctrl #(
    .CHIRP_STEPS(CHIRP_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  tcfs_dp #(
    .CHIRP_STEPS(CHIRP_STEPS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (dp_cmd),
    .status         (dp_status),
    .in_req_type    (cmd.req_type),
    .in_start_freq  (cmd.start_freq),
    .in_end_freq    (cmd.end_freq),
    .in_duration_ms (cmd.duration_ms),
    .in_volume      (cmd.volume),
    .in_fade_on     (cmd.fade_on),
    .cfg            (cfg),
    .seg            (seg)
  );

endmodule

// ----- verif/tcfs_seg_checker.sv -----
// Checker that predicts the buzzer segments of every accepted command and compares them.
`timescale 1ns / 1ps
module tcfs_seg_checker #(
  parameter int unsigned CHIRP_STEPS = 20
) (
  input  logic        clk,
  input  logic        rst,
  tcfs_cmd_if         cmd,
  tcfs_seg_if         seg,
  tcfs_cfg_if         cfg,
  output int unsigned mismatch_count,
  output int unsigned segs_due
);
  import tcfs_pkg::*;

  typedef struct packed {
    logic [15:0] tone_freq;
    logic [7:0]  duty;
    logic [15:0] hold_ms;
    logic        last;
  } segment_t;

  segment_t    due_q[$];
  logic [6:0]  master_pct;
  logic        muted;
  int unsigned mismatches = 0;

  function automatic logic [7:0] volume_duty(input logic [7:0] vol);
    int unsigned v;
    int unsigned m;
    if (muted) return 8'd0;
    v = (vol > 8'd100) ? 100 : vol;
    m = (master_pct > 7'd100) ? 100 : master_pct;
    v = v * m / 100;
    v = v * 255 / 100;
    return v[7:0];
  endfunction

  function automatic void add_seg(input logic [15:0] freq, input logic [7:0] duty,
                                  input logic [15:0] hold, input logic last);
    due_q.push_back('{freq, duty, hold, last});
  endfunction

  function automatic void plan_segments(input logic [1:0] kind, input logic [15:0] f0,
                                        input logic [15:0] f1, input logic [15:0] dur,
                                        input logic [7:0] vol, input logic fade);
    int          steps;
    int          df;
    int          freq;
    int          lvl;
    int unsigned d;
    int unsigned steady;
    int unsigned fade_step;
    steps = CHIRP_STEPS;
    if (kind == REQ_SILENCE) begin
      add_seg(16'd0, 8'd0, dur, 1'b1);
      return;
    end
    d = volume_duty(vol);
    if (kind == REQ_CHIRP) begin
      // Signed division, so a falling sweep truncates toward zero as well.
      df = (int'(f1) - int'(f0)) / steps;
      for (int i = 0; i < steps; i++) begin
        freq = int'(f0) + df * i;
        add_seg(freq[15:0], d[7:0], 16'(dur / CHIRP_STEPS), 1'b0);
      end
    end else if (!fade) begin
      add_seg(f0, d[7:0], dur, 1'b0);
    end else begin
      steady = dur * 7 / 10;
      fade_step = (d / 8 < 1) ? 1 : d / 8;
      add_seg(f0, d[7:0], 16'(steady), 1'b0);
      for (lvl = d; lvl > 0; lvl -= fade_step) begin
        add_seg(f0, lvl[7:0], 16'((dur - steady) / 8), 1'b0);
      end
    end
    add_seg(16'd0, 8'd0, 16'd0, 1'b1);
  endfunction

  always @(posedge clk) begin : watch
    segment_t got;
    segment_t want;
    if (rst) begin
      master_pct = 7'd70;
      muted = 1'b0;
      due_q.delete();
    end else begin
      // Results are checked before this edge's command is planned, so a segment
      // always meets the expectations of commands taken at earlier edges.
      if (seg.valid && seg.ready) begin
        got = '{seg.tone_freq, seg.duty, seg.hold_ms, seg.last};
        if (due_q.size() == 0) begin
          $error("segment with no command outstanding: freq %0d duty %0d hold %0d last %0b",
                 got.tone_freq, got.duty, got.hold_ms, got.last);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          if (got.tone_freq !== want.tone_freq) begin
            $error("tone_freq: expected %0d, got %0d", want.tone_freq, got.tone_freq);
            mismatches++;
          end
          if (got.duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, got.duty);
            mismatches++;
          end
          if (got.hold_ms !== want.hold_ms) begin
            $error("hold_ms: expected %0d, got %0d", want.hold_ms, got.hold_ms);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          CFG_MASTER_VOLUME: master_pct = cfg.wdata;
          CFG_MUTE_ON:       muted = cfg.wdata[0];
          default:           ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        plan_segments(cmd.req_type, cmd.start_freq, cmd.end_freq, cmd.duration_ms,
                      cmd.volume, cmd.fade_on);
      end
    end
    mismatch_count <= mismatches;
    segs_due <= due_q.size();
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top: drives commands and register writes into the sequencer and gives the verdict.
`timescale 1ns / 1ps
// The block turns each command transfer into a run of buzzer segments. A checker beside
// the block predicts every run from the commands and register writes it sees and compares
// each segment transfer field by field; this module only makes stimulus. The run starts
// with a directed set of commands at the reset register values (both field extremes,
// every command kind, the spare kind code, fade levels that give no step and many steps,
// chirps whose step truncates to zero, rising and falling sweeps). It then walks through
// several register settings, written only after all expected segments are back, each
// followed by random commands. The sender idles in short random bursts and now and then
// holds off until the block is drained; the segment side stalls in bursts as well. The
// final setting runs with neither side idling.
module tb;
  import tcfs_pkg::*;

  localparam int unsigned STEPS = 20;
  // The two-bit kind field has one spare code, which the block plays as a tone.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int unsigned NUM_PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  logic sender_gaps = 1'b1;
  int unsigned mismatch_count;
  int unsigned segs_due;

  tcfs_cmd_if cmd_ch ();
  tcfs_seg_if seg_ch ();
  tcfs_cfg_if cfg_ch ();

  always #2 clk = ~clk;

  tone_chirp_fade_sequencer_top #(.CHIRP_STEPS(STEPS)) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .seg (seg_ch),
    .cfg (cfg_ch)
  );

  tcfs_seg_checker #(.CHIRP_STEPS(STEPS)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .seg            (seg_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatch_count),
    .segs_due       (segs_due)
  );

  // Offers one command and returns at the edge where it is taken. Valid stays high, so
  // back-to-back commands go out with no gap; the next call or a pause changes it.
  task automatic issue(input logic [1:0] kind, input logic [15:0] f0, input logic [15:0] f1,
                       input logic [15:0] dur, input logic [7:0] vol, input logic fade);
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.req_type <= kind;
    cmd_ch.start_freq <= f0;
    cmd_ch.end_freq <= f1;
    cmd_ch.duration_ms <= dur;
    cmd_ch.volume <= vol;
    cmd_ch.fade_on <= fade;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Sender idle burst of the given number of cycles.
  task automatic pause_cmd(input int unsigned cycles);
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Holds off the sender until every predicted segment has come out.
  task automatic drain();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (segs_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic issue_random();
    int unsigned pick;
    logic [1:0]  kind;
    logic [15:0] f0;
    logic [15:0] f1;
    logic [15:0] dur;
    logic [7:0]  vol;
    pick = $urandom_range(0, 99);
    if (pick < 40) kind = REQ_TONE;
    else if (pick < 70) kind = REQ_CHIRP;
    else if (pick < 85) kind = REQ_SILENCE;
    else kind = REQ_SPARE;
    f0 = 16'($urandom);
    // Close end frequencies make the chirp step land near zero on either side.
    f1 = ($urandom_range(0, 3) == 0) ? f0 + 16'($urandom_range(0, 40)) - 16'd20
                                      : 16'($urandom);
    dur = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 100)) : 16'($urandom);
    // Low volumes give small duties, and small duties give the longest fades.
    case ($urandom_range(0, 3))
      0:       vol = 8'($urandom_range(0, 20));
      1:       vol = 8'($urandom_range(0, 100));
      2:       vol = 8'($urandom_range(100, 255));
      default: vol = 8'($urandom);
    endcase
    issue(kind, f0, f1, dur, vol, 1'($urandom));
  endtask

  // Segment side: ready runs of random length broken by stall bursts, except in the
  // final part of the run where it stays ready.
  initial begin : sink_side
    int unsigned run;
    seg_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (calm) begin
        seg_ch.ready <= 1'b1;
        @(negedge clk);
      end else begin
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 25);
        seg_ch.ready <= 1'b1;
        repeat (run) @(negedge clk);
        seg_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [6:0] master;
    logic       mute;
    cmd_ch.valid <= 1'b0;
    cmd_ch.req_type <= REQ_TONE;
    cmd_ch.start_freq <= 16'd0;
    cmd_ch.end_freq <= 16'd0;
    cmd_ch.duration_ms <= 16'd0;
    cmd_ch.volume <= 8'd0;
    cmd_ch.fade_on <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= CFG_MASTER_VOLUME;
    cfg_ch.wdata <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed commands at the reset setting: master volume 70, not muted.
    issue(REQ_SILENCE, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0);
    issue(REQ_SILENCE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    issue(REQ_TONE, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0);
    issue(REQ_TONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
    issue(REQ_TONE, 16'd440, 16'd0, 16'd1000, 8'd100, 1'b1);
    issue(REQ_TONE, 16'd880, 16'd0, 16'hFFFF, 8'hFF, 1'b1);
    // A fade from zero duty has no steps at all.
    issue(REQ_TONE, 16'd1000, 16'd0, 16'd500, 8'd0, 1'b1);
    issue(REQ_TONE, 16'd1, 16'd0, 16'd1, 8'd1, 1'b1);
    // Duties below sixteen fade one level per step, which gives the longest runs.
    issue(REQ_TONE, 16'd2000, 16'd0, 16'd9, 8'd6, 1'b1);
    issue(REQ_TONE, 16'd3000, 16'd0, 16'd0, 8'd9, 1'b1);
    issue(REQ_TONE, 16'd500, 16'd0, 16'd100, 8'd101, 1'b0);
    issue(REQ_CHIRP, 16'd100, 16'd2100, 16'd1000, 8'd50, 1'b0);
    issue(REQ_CHIRP, 16'd5000, 16'd100, 16'd2000, 8'd80, 1'b0);
    issue(REQ_CHIRP, 16'd0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    issue(REQ_CHIRP, 16'hFFFF, 16'd0, 16'd19, 8'd100, 1'b0);
    // Sweeps narrower than one step truncate toward zero, upward and downward; one just wider steps down by one.
    issue(REQ_CHIRP, 16'd1000, 16'd1019, 16'd20, 8'd40, 1'b0);
    issue(REQ_CHIRP, 16'd1019, 16'd1000, 16'd40, 8'd40, 1'b0);
    issue(REQ_CHIRP, 16'd1000, 16'd979, 16'd100, 8'd40, 1'b0);
    issue(REQ_CHIRP, 16'd777, 16'd777, 16'd300, 8'd30, 1'b1);
    issue(REQ_SPARE, 16'd1234, 16'd4321, 16'd3000, 8'd60, 1'b1);
    issue(REQ_SPARE, 16'd1234, 16'd4321, 16'd3000, 8'd60, 1'b0);
    issue(REQ_SPARE, 16'hFFFF, 16'd0, 16'hFFFF, 8'hFF, 1'b1);

    // Each phase starts from a drained block with a new register setting: full scale,
    // above range, zero, muted, then random ones. The last phase runs without idling.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0:       begin master = 7'd100; mute = 1'b0; end
        1:       begin master = 7'd127; mute = 1'b0; end
        2:       begin master = 7'd0;   mute = 1'b0; end
        3:       begin master = 7'd70;  mute = 1'b1; end
        4:       begin master = 7'($urandom); mute = 1'b0; end
        5:       begin master = 7'($urandom); mute = 1'($urandom); end
        default: begin master = 7'($urandom_range(60, 100)); mute = 1'b0; end
      endcase
      write_reg(CFG_MASTER_VOLUME, master);
      // Only bit zero counts for the mute flag; the upper data bits are noise.
      write_reg(CFG_MUTE_ON, {6'($urandom), mute});
      sender_gaps = (phase != 2);
      calm = (phase == NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
          pause_cmd($urandom_range(1, 9));
        end
        if (!calm && $urandom_range(0, 39) == 0) begin
          drain();
        end
        issue_random();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run: every command a full chirp with
  // each segment waiting out a full stall.
  initial begin : watchdog
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
